@@ src/scws_pkg.sv @@
// shared constants, types and helper functions for the spring column wave block
package scws_pkg;

   localparam int COLUMNS           = 64;
   localparam int PIXELS_PER_COLUMN = 15;
   localparam int SPREAD_PASSES     = 4;
   localparam int WAVE_TABLE_LEN    = 24;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CNT_W  = 7;
   localparam int PASS_W = (SPREAD_PASSES > 1) ? $clog2(SPREAD_PASSES) : 1;
   localparam int WP_W   = $clog2(WAVE_TABLE_LEN);
   localparam int POS_W  = 10;
   localparam int CFG_W  = 16;

   // pixel to column by reciprocal multiply, exact for every 10-bit position
   localparam int DIV_SHIFT    = 16;
   localparam int SPLASH_RECIP = ((1 << DIV_SHIFT) + PIXELS_PER_COLUMN - 1) / PIXELS_PER_COLUMN;
   localparam int RECIP_W      = DIV_SHIFT + 1;
   localparam int DIVP_W       = POS_W + RECIP_W;

   typedef enum logic [1:0] {
      CSR_TENSION = 2'd0,
      CSR_DAMPING = 2'd1,
      CSR_SPREAD  = 2'd2,
      CSR_ACTIVE  = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_SPR_RD,
      DP_SPR_MUL,
      DP_SPR_SUM,
      DP_SPR_MUL2,
      DP_SPR_WR,
      DP_PRIME_RD,
      DP_PRIME_LD,
      DP_SPD_RD,
      DP_SPD_MUL1,
      DP_SPD_MUL2,
      DP_SPD_SUM,
      DP_SPD_WR,
      DP_EDGE_MUL,
      DP_EDGE_WR0,
      DP_EDGE_WR1,
      DP_OUT_RD,
      DP_OUT_LD,
      DP_SPL_WR
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPL_CHK,
      ST_SPL_MID,
      ST_SPL_LO,
      ST_SPL_HI,
      ST_SPR_RD,
      ST_SPR_MUL,
      ST_SPR_SUM,
      ST_SPR_MUL2,
      ST_SPR_WR,
      ST_PRIME_RD,
      ST_PRIME_LD,
      ST_SPD_RD,
      ST_SPD_MUL1,
      ST_SPD_MUL2,
      ST_SPD_SUM,
      ST_SPD_WR,
      ST_EDGE_MUL,
      ST_EDGE_WR0,
      ST_EDGE_WR1,
      ST_OUT_RD,
      ST_OUT_LD
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type        op;
      logic [COL_W-1:0] col;
      logic             take;
   } dp_cmd_type;

   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [POS_W-1:0] splash_idx;
      logic             rsp_busy;
   } dp_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // one period of the edge wave, Q16.16
   function automatic logic signed [31:0] wave_entry(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:    v = 32'sd0;
         5'd1:    v = 32'sd12452;
         5'd2:    v = 32'sd24904;
         5'd3:    v = 32'sd36700;
         5'd4:    v = 32'sd46531;
         5'd5:    v = 32'sd55050;
         5'd6:    v = 32'sd60948;
         5'd7:    v = 32'sd64225;
         5'd8:    v = 32'sd64881;
         5'd9:    v = 32'sd63570;
         5'd10:   v = 32'sd58982;
         5'd11:   v = 32'sd52429;
         5'd12:   v = 32'sd43909;
         5'd13:   v = 32'sd33423;
         5'd14:   v = 32'sd21627;
         5'd15:   v = 32'sd9175;
         5'd16:   v = 32'sd0;
         5'd17:   v = -32'sd24904;
         5'd18:   v = -32'sd46531;
         5'd19:   v = -32'sd60948;
         5'd20:   v = -32'sd64881;
         5'd21:   v = -32'sd58982;
         5'd22:   v = -32'sd43909;
         5'd23:   v = -32'sd21627;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/spring_column_wave_sim.sv @@
// top level of the spring column water surface simulator
// a splash item gives no result
// a tick item steps the datapath over every active column, once in the spring
// pass and once in every spread pass, then streams one result per active column
// reset: synchronous, heights, speeds and wave position read as zero, registers at defaults
module spring_column_wave_sim import scws_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // configuration writes
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   // request items
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [15:0]         req_tick_dt,
   input  logic [15:0]         req_wave_gain,
   input  logic [POS_W-1:0]    req_splash_position,
   input  logic signed [31:0]  req_splash_speed,
   // result items, one per active column after a tick
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COL_W-1:0]    rsp_column_index,
   output logic signed [31:0]  rsp_column_height,
   output logic                rsp_last_column
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer walks columns and passes, one column step at a time
   scws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath holds the column rams, the multipliers and the result register;
   // the result register lets the sequencer go idle while the last item waits
   scws_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_tick_dt         (req_tick_dt),
      .req_wave_gain       (req_wave_gain),
      .req_splash_position (req_splash_position),
      .req_splash_speed    (req_splash_speed),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_column_index    (rsp_column_index),
      .rsp_column_height   (rsp_column_height),
      .rsp_last_column     (rsp_last_column)
   );

`ifndef SYNTH
   // no new item is taken while the datapath is busy with a step
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != DP_NOP) |-> !req_ready)
      else $error("item accepted while datapath busy");

   // an accepted item always leaves the idle state
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer stayed idle after accept");

   // a result that is still waiting stays valid while the next load is held
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_OUT_LD && sts.rsp_busy) |=> rsp_valid)
      else $error("pending result dropped");
`endif

endmodule

@@ src/scws_ram.sv @@
// generic single write port ram with registered read
module scws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/scws_ctrl.sv @@
// sequencer for splash writes, spring pass, spread passes, edge drive and readout
module scws_ctrl import scws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type    state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      pass_in   = pass_ff;
      req_ready = 1'b0;
      cmd.op    = DP_NOP;
      cmd.col   = col_ff;
      cmd.take  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is held
            req_ready = !reset;
            cmd.take  = req_valid;
            if (req_valid) begin
               col_in   = '0;
               state_in = req_type ? ST_SPL_CHK : ST_SPR_RD;
            end
         end
         ST_SPL_CHK: begin
            if (sts.splash_idx > POS_W'(sts.last_col)) begin
               state_in = ST_IDLE;
            end else begin
               col_in   = sts.splash_idx[COL_W-1:0];
               state_in = ST_SPL_MID;
            end
         end
         ST_SPL_MID: begin
            cmd.op = DP_SPL_WR;
            if (col_ff != '0) begin
               col_in   = col_ff - 1'b1;
               state_in = ST_SPL_LO;
            end else if (col_ff != sts.last_col) begin
               col_in   = col_ff + 1'b1;
               state_in = ST_SPL_HI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SPL_LO: begin
            cmd.op = DP_SPL_WR;
            if (COL_W'(col_ff + 1'b1) != sts.last_col) begin
               col_in   = COL_W'(col_ff + 2'd2);
               state_in = ST_SPL_HI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SPL_HI: begin
            cmd.op   = DP_SPL_WR;
            state_in = ST_IDLE;
         end
         ST_SPR_RD: begin
            cmd.op   = DP_SPR_RD;
            state_in = ST_SPR_MUL;
         end
         ST_SPR_MUL: begin
            cmd.op   = DP_SPR_MUL;
            state_in = ST_SPR_SUM;
         end
         ST_SPR_SUM: begin
            cmd.op   = DP_SPR_SUM;
            state_in = ST_SPR_MUL2;
         end
         ST_SPR_MUL2: begin
            cmd.op   = DP_SPR_MUL2;
            state_in = ST_SPR_WR;
         end
         ST_SPR_WR: begin
            cmd.op = DP_SPR_WR;
            if (col_ff == sts.last_col) begin
               col_in   = '0;
               pass_in  = '0;
               state_in = ST_PRIME_RD;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_SPR_RD;
            end
         end
         ST_PRIME_RD: begin
            cmd.op   = DP_PRIME_RD;
            state_in = ST_PRIME_LD;
         end
         ST_PRIME_LD: begin
            cmd.op   = DP_PRIME_LD;
            state_in = ST_SPD_RD;
         end
         ST_SPD_RD: begin
            cmd.op   = DP_SPD_RD;
            state_in = ST_SPD_MUL1;
         end
         ST_SPD_MUL1: begin
            cmd.op   = DP_SPD_MUL1;
            state_in = ST_SPD_MUL2;
         end
         ST_SPD_MUL2: begin
            cmd.op   = DP_SPD_MUL2;
            state_in = ST_SPD_SUM;
         end
         ST_SPD_SUM: begin
            cmd.op   = DP_SPD_SUM;
            state_in = ST_SPD_WR;
         end
         ST_SPD_WR: begin
            cmd.op = DP_SPD_WR;
            if (col_ff == sts.last_col) begin
               col_in = '0;
               if (pass_ff == PASS_W'(SPREAD_PASSES - 1)) begin
                  state_in = ST_EDGE_MUL;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  state_in = ST_PRIME_RD;
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_SPD_RD;
            end
         end
         ST_EDGE_MUL: begin
            cmd.op   = DP_EDGE_MUL;
            state_in = ST_EDGE_WR0;
         end
         ST_EDGE_WR0: begin
            cmd.op   = DP_EDGE_WR0;
            state_in = ST_EDGE_WR1;
         end
         ST_EDGE_WR1: begin
            cmd.op   = DP_EDGE_WR1;
            col_in   = '0;
            state_in = ST_OUT_RD;
         end
         ST_OUT_RD: begin
            cmd.op   = DP_OUT_RD;
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            cmd.op = DP_OUT_LD;
            if (!sts.rsp_busy) begin
               if (col_ff == sts.last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/scws_dp.sv @@
// column datapath: config registers, column rams, multipliers and result register
module scws_dp import scws_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wdata,
   input  logic [15:0]              req_tick_dt,
   input  logic [15:0]              req_wave_gain,
   input  logic [POS_W-1:0]         req_splash_position,
   input  logic signed [31:0]       req_splash_speed,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [COL_W-1:0]         rsp_column_index,
   output logic signed [31:0]       rsp_column_height,
   output logic                     rsp_last_column
);

   logic [15:0]        tension_ff, damping_ff, spread_ff;
   logic [CNT_W-1:0]   active_ff;
   logic [CNT_W-1:0]   n_cols;
   logic [COL_W-1:0]   last_col;

   logic [15:0]        dt_ff, gain_ff;
   logic [POS_W-1:0]   pos_ff;
   logic signed [31:0] speed_ff;
   logic [DIVP_W-1:0]  div_prod;

   logic               h_we, s_we;
   logic [COL_W-1:0]   h_waddr, s_waddr, h_raddr;
   logic signed [31:0] h_wdata, s_wdata, h_rd, s_rd, h_m, s_m;
   logic [COLUMNS-1:0] h_valid_ff, s_valid_ff;
   logic               h_vld_rd_ff, s_vld_rd_ff;

   logic signed [16:0] tens17, damp17, spr17, dt17, gain17;

   // spring pass
   logic signed [32:0] neg_h;
   logic signed [49:0] spr_tprod;
   logic signed [48:0] spr_dprod;
   logic signed [41:0] a_ff;
   logic signed [32:0] b_ff;
   logic signed [31:0] s_hold_ff, h_hold_ff, snew_ff;
   logic signed [48:0] p_ff, p_prod;
   logic signed [31:0] spr_hnew, spr_snew;

   // spread passes
   logic signed [31:0] hm_ff, hc_ff, hn_ff;
   logic signed [32:0] diff_r, diff_l;
   logic signed [49:0] pr_prod, pl_prod;
   logic signed [41:0] tr_ff, tl_ff;
   logic signed [34:0] hi_r_ff, hi_l_ff, hi_r, hi_l;
   logic signed [41:0] lo_r_ff, lo_l_ff, lo_r, lo_l;
   logic signed [63:0] full_r, full_l;
   logic signed [31:0] rp_ff, lp_ff;
   logic signed [31:0] s1, s2, h1, h2;

   // edge drive
   logic [WP_W-1:0]    wp_ff, wp_in;
   logic signed [48:0] eprod_ff, eprod;
   logic signed [31:0] edge_val;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [COL_W-1:0]   rsp_index_ff;
   logic signed [31:0] rsp_height_ff;
   logic               rsp_busy;

   // active count clamp
   always_comb begin
      if (active_ff < CNT_W'(2)) begin
         n_cols = CNT_W'(2);
      end else if (active_ff > CNT_W'(COLUMNS)) begin
         n_cols = CNT_W'(COLUMNS);
      end else begin
         n_cols = active_ff;
      end
   end
   assign last_col = COL_W'(n_cols - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= 16'd742;
         damping_ff <= 16'd590;
         spread_ff  <= 16'd8960;
         active_ff  <= CNT_W'(COLUMNS);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TENSION: tension_ff <= csr_wdata;
            CSR_DAMPING: damping_ff <= csr_wdata;
            CSR_SPREAD:  spread_ff  <= csr_wdata;
            CSR_ACTIVE:  active_ff  <= csr_wdata[CNT_W-1:0];
            default:     tension_ff <= tension_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         dt_ff    <= req_tick_dt;
         gain_ff  <= req_wave_gain;
         pos_ff   <= req_splash_position;
         speed_ff <= req_splash_speed;
      end
   end

   assign div_prod = DIVP_W'(pos_ff) * DIVP_W'(SPLASH_RECIP);

   assign tens17 = {1'b0, tension_ff};
   assign damp17 = {1'b0, damping_ff};
   assign spr17  = {1'b0, spread_ff};
   assign dt17   = {1'b0, dt_ff};
   assign gain17 = {1'b0, gain_ff};

   // column memories, entries never written since clear read as zero
   assign h_raddr = (cmd.op == DP_SPD_RD) ? COL_W'(cmd.col + 1'b1) : cmd.col;

   scws_ram #(.WIDTH(32), .DEPTH(COLUMNS)) u_height_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rd)
   );

   scws_ram #(.WIDTH(32), .DEPTH(COLUMNS)) u_speed_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (cmd.col),
      .rd_data (s_rd)
   );

   always_ff @(posedge clock) begin
      if (reset || (csr_wr_en && csr_index_type'(csr_index) == CSR_ACTIVE)) begin
         h_valid_ff <= '0;
         s_valid_ff <= '0;
      end else begin
         if (h_we) begin
            h_valid_ff[h_waddr] <= 1'b1;
         end
         if (s_we) begin
            s_valid_ff[s_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_vld_rd_ff <= h_valid_ff[h_raddr];
      s_vld_rd_ff <= s_valid_ff[cmd.col];
   end

   assign h_m = h_vld_rd_ff ? h_rd : 32'sd0;
   assign s_m = s_vld_rd_ff ? s_rd : 32'sd0;

   // arithmetic
   always_comb begin
      neg_h     = -{h_m[31], h_m};
      spr_tprod = neg_h * tens17;
      spr_dprod = s_m * damp17;
      p_prod    = snew_ff * dt17;
      spr_snew  = sat32(64'(s_hold_ff) + 64'(a_ff) - 64'(b_ff));
      spr_hnew  = sat32(64'(h_hold_ff) + 64'(p_ff >>> 16));

      diff_r  = 33'(hm_ff) - 33'(hc_ff);
      diff_l  = 33'(h_m) - 33'(hc_ff);
      pr_prod = diff_r * spr17;
      pl_prod = diff_l * spr17;
      hi_r    = $signed(tr_ff[41:24]) * dt17;
      hi_l    = $signed(tl_ff[41:24]) * dt17;
      lo_r    = $signed({1'b0, tr_ff[23:0]}) * dt17;
      lo_l    = $signed({1'b0, tl_ff[23:0]}) * dt17;
      full_r  = (64'(hi_r_ff) <<< 24) + 64'(lo_r_ff);
      full_l  = (64'(hi_l_ff) <<< 24) + 64'(lo_l_ff);

      // right pull of the left neighbor lands first, then left pull of the right one
      s1 = (cmd.col != '0) ? sat32(64'(s_hold_ff) + 64'(rp_ff)) : s_hold_ff;
      s2 = (cmd.col != last_col) ? sat32(64'(s1) + 64'(lp_ff)) : s1;
      h1 = (cmd.col != '0) ? sat32(64'(hc_ff) + 64'(rp_ff)) : hc_ff;
      h2 = (cmd.col != last_col) ? sat32(64'(h1) + 64'(lp_ff)) : h1;

      wp_in    = (wp_ff == WP_W'(WAVE_TABLE_LEN - 1)) ? '0 : WP_W'(wp_ff + 1'b1);
      eprod    = wave_entry(5'(wp_in)) * gain17;
      edge_val = sat32(64'(eprod_ff >>> 14));
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_SPR_MUL: begin
            a_ff      <= 42'(spr_tprod >>> 8);
            b_ff      <= 33'(spr_dprod >>> 16);
            s_hold_ff <= s_m;
            h_hold_ff <= h_m;
         end
         DP_SPR_SUM:  snew_ff <= spr_snew;
         DP_SPR_MUL2: p_ff    <= p_prod;
         DP_PRIME_LD: hc_ff   <= h_m;
         DP_SPD_MUL1: begin
            tr_ff     <= 42'(pr_prod >>> 8);
            tl_ff     <= 42'(pl_prod >>> 8);
            hn_ff     <= h_m;
            s_hold_ff <= s_m;
         end
         DP_SPD_MUL2: begin
            hi_r_ff <= hi_r;
            hi_l_ff <= hi_l;
            lo_r_ff <= lo_r;
            lo_l_ff <= lo_l;
         end
         DP_SPD_SUM: begin
            rp_ff <= sat32(full_r >>> 16);
            lp_ff <= sat32(full_l >>> 16);
         end
         DP_SPD_WR: begin
            hm_ff <= hc_ff;
            hc_ff <= hn_ff;
         end
         DP_EDGE_MUL: eprod_ff <= eprod;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (cmd.op == DP_EDGE_MUL) begin
         wp_ff <= wp_in;
      end
   end

   // memory write ports
   always_comb begin
      h_we    = 1'b0;
      h_waddr = cmd.col;
      h_wdata = h2;
      s_we    = 1'b0;
      s_waddr = cmd.col;
      s_wdata = s2;
      case (cmd.op)
         DP_SPR_WR: begin
            h_we    = 1'b1;
            h_wdata = spr_hnew;
            s_we    = 1'b1;
            s_wdata = snew_ff;
         end
         DP_SPD_WR: begin
            h_we = 1'b1;
            s_we = 1'b1;
         end
         DP_EDGE_WR0: begin
            h_we    = 1'b1;
            h_waddr = '0;
            h_wdata = edge_val;
         end
         DP_EDGE_WR1: begin
            h_we    = 1'b1;
            h_waddr = last_col;
            h_wdata = sat32(-64'(edge_val));
         end
         DP_SPL_WR: begin
            s_we    = 1'b1;
            s_wdata = speed_ff;
         end
         default: begin
         end
      endcase
   end

   // result register
   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_OUT_LD && !rsp_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_OUT_LD && !rsp_busy) begin
         rsp_index_ff  <= cmd.col;
         rsp_height_ff <= h_m;
         rsp_last_ff   <= (cmd.col == last_col);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_index  = rsp_index_ff;
   assign rsp_column_height = rsp_height_ff;
   assign rsp_last_column   = rsp_last_ff;

   assign sts.last_col   = last_col;
   assign sts.splash_idx = div_prod[DIV_SHIFT +: POS_W];
   assign sts.rsp_busy   = rsp_busy;

endmodule

@@ verif/scws_checker.sv @@
// checker for the spring column wave block: predicts column heights and compares results
module scws_checker import scws_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_type,
   input  logic [15:0]         req_tick_dt,
   input  logic [15:0]         req_wave_gain,
   input  logic [POS_W-1:0]    req_splash_position,
   input  logic signed [31:0]  req_splash_speed,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [COL_W-1:0]    rsp_column_index,
   input  logic signed [31:0]  rsp_column_height,
   input  logic                rsp_last_column,
   output int                  fail_count,
   output int                  heights_pending
);

   typedef struct {
      logic [COL_W-1:0]   index;
      logic signed [31:0] height;
      logic               last;
   } column_report_type;

   column_report_type  height_queue[$];
   logic signed [31:0] col_height[COLUMNS];
   logic signed [31:0] col_speed[COLUMNS];
   logic signed [31:0] pull_left[COLUMNS];
   logic signed [31:0] pull_right[COLUMNS];
   logic [15:0]        tension_q, damping_q, spread_q;
   logic [6:0]         active_q;
   int                 wave_idx;

   assign heights_pending = height_queue.size();

   function automatic logic signed [31:0] clip32(input longint x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic int used_columns();
      int n;
      n = active_q;
      if (n < 2) n = 2;
      if (n > COLUMNS) n = COLUMNS;
      return n;
   endfunction

   function automatic logic signed [31:0] neighbour_pull(input longint diff, input longint dt);
      longint t;
      t = (diff * longint'(spread_q)) >>> 8;
      return clip32((t * dt) >>> 16);
   endfunction

   task automatic clear_surface();
      for (int i = 0; i < COLUMNS; i++) begin
         col_height[i] = 0;
         col_speed[i]  = 0;
      end
   endtask

   // one tick: spring, spread passes, edge drive, then queue every active height
   task automatic advance_tick(input logic [15:0] dt_in, input logic [15:0] gain_in);
      int                 n;
      longint             s, h, dt;
      logic signed [31:0] edge_h;
      column_report_type  rep;
      n  = used_columns();
      dt = longint'(dt_in);
      for (int i = 0; i < n; i++) begin
         s = col_speed[i];
         h = col_height[i];
         s = s + ((-h * longint'(tension_q)) >>> 8) - ((s * longint'(damping_q)) >>> 16);
         col_speed[i]  = clip32(s);
         col_height[i] = clip32(h + ((longint'(col_speed[i]) * dt) >>> 16));
      end
      for (int p = 0; p < SPREAD_PASSES; p++) begin
         for (int j = 0; j < n; j++) begin
            if (j > 0) begin
               pull_left[j] = neighbour_pull(longint'(col_height[j]) - col_height[j-1], dt);
               col_speed[j-1] = clip32(longint'(col_speed[j-1]) + pull_left[j]);
            end
            if (j + 1 < n) begin
               pull_right[j] = neighbour_pull(longint'(col_height[j]) - col_height[j+1], dt);
               col_speed[j+1] = clip32(longint'(col_speed[j+1]) + pull_right[j]);
            end
         end
         for (int j = 0; j < n; j++) begin
            if (j > 0) col_height[j-1] = clip32(longint'(col_height[j-1]) + pull_left[j]);
            if (j + 1 < n) col_height[j+1] = clip32(longint'(col_height[j+1]) + pull_right[j]);
         end
      end
      wave_idx = (wave_idx + 1) % WAVE_TABLE_LEN;
      case (wave_idx)
         1: edge_h = 12452;    2: edge_h = 24904;    3: edge_h = 36700;
         4: edge_h = 46531;    5: edge_h = 55050;    6: edge_h = 60948;
         7: edge_h = 64225;    8: edge_h = 64881;    9: edge_h = 63570;
         10: edge_h = 58982;   11: edge_h = 52429;   12: edge_h = 43909;
         13: edge_h = 33423;   14: edge_h = 21627;   15: edge_h = 9175;
         17: edge_h = -24904;  18: edge_h = -46531;  19: edge_h = -60948;
         20: edge_h = -64881;  21: edge_h = -58982;  22: edge_h = -43909;
         23: edge_h = -21627;
         default: edge_h = 0;
      endcase
      edge_h = clip32((longint'(edge_h) * longint'(gain_in)) >>> 14);
      col_height[0]   = edge_h;
      col_height[n-1] = clip32(-longint'(edge_h));
      for (int i = 0; i < n; i++) begin
         rep.index  = i[COL_W-1:0];
         rep.height = col_height[i];
         rep.last   = (i + 1 == n);
         height_queue.insert(height_queue.size(), rep);
      end
   endtask

   task automatic apply_splash(input logic [POS_W-1:0] pos, input logic signed [31:0] spd);
      int n, idx;
      n   = used_columns();
      idx = int'(pos) / PIXELS_PER_COLUMN;
      if (idx < n) begin
         col_speed[idx] = spd;
         if (idx > 0) col_speed[idx-1] = spd;
         if (idx + 1 < n) col_speed[idx+1] = spd;
      end
   endtask

   always @(posedge clock) begin
      column_report_type want;
      if (reset) begin
         tension_q = 742;
         damping_q = 590;
         spread_q  = 8960;
         active_q  = 64;
         wave_idx  = 0;
         clear_surface();
         height_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_TENSION: tension_q = csr_wdata;
               CSR_DAMPING: damping_q = csr_wdata;
               CSR_SPREAD:  spread_q  = csr_wdata;
               CSR_ACTIVE: begin
                  active_q = csr_wdata[6:0];
                  clear_surface();
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (height_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: column %0d height %0d last %0d",
                           rsp_column_index, rsp_column_height, rsp_last_column);
            end else begin
               want = height_queue.pop_front();
               if (want.index !== rsp_column_index || want.height !== rsp_column_height ||
                   want.last !== rsp_last_column) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected col %0d h %0d last %0d, got col %0d h %0d last %0d",
                              want.index, want.height, want.last,
                              rsp_column_index, rsp_column_height, rsp_last_column);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type) apply_splash(req_splash_position, req_splash_speed);
            else advance_tick(req_tick_dt, req_wave_gain);
         end
      end
   end

   initial fail_count = 0;

endmodule

@@ verif/tb_spring_column_wave_sim.sv @@
// testbench top for the spring column wave block: stimulus, idling phases and verdict
module tb_spring_column_wave_sim;
   import scws_pkg::*;

   localparam int IDLE_LIMIT = 40000;  // cycles without any handshake before giving up

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [CFG_W-1:0]   csr_wdata;
   logic               req_valid, req_ready, req_type;
   logic [15:0]        req_tick_dt, req_wave_gain;
   logic [POS_W-1:0]   req_splash_position;
   logic signed [31:0] req_splash_speed;
   logic               rsp_valid, rsp_ready;
   logic [COL_W-1:0]   rsp_column_index;
   logic signed [31:0] rsp_column_height;
   logic               rsp_last_column;
   int                 fail_count, heights_pending;
   int                 send_idle_pct, recv_stall_pct, quiet_cycles;

   spring_column_wave_sim dut (.*);
   scws_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stalls at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: a run of cycles past IDLE_LIMIT with no handshake at all is a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every predicted height has come out, then let a splash finish
   task automatic settle_surface();
      while (heights_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one item through the request handshake, with random gaps ahead of it
   task automatic send_item(input logic kind, input logic [15:0] dt, input logic [15:0] gain,
                            input logic [POS_W-1:0] pos, input logic signed [31:0] spd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_tick_dt         <= dt;
      req_wave_gain       <= gain;
      req_splash_position <= pos;
      req_splash_speed    <= spd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_tick(input logic [15:0] dt, input logic [15:0] gain);
      send_item(1'b0, dt, gain, POS_W'($urandom), $urandom);
   endtask

   task automatic send_splash(input logic [POS_W-1:0] pos, input logic signed [31:0] spd);
      send_item(1'b1, 16'($urandom), 16'($urandom), pos, spd);
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
      @(posedge clock);
      settle_surface();
   endtask

   // random mix: splashes and ticks interleaved at random, ticks more often, so the surface actually moves
   task automatic random_items(input int count);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1, 2: send_splash(POS_W'($urandom), $urandom);
            3: send_splash(POS_W'($urandom_range(1023, 900)), $urandom);  // often off the surface
            default: begin
               if ($urandom_range(3) == 0) begin
                  send_tick(16'($urandom_range(65535, 60000)), 16'($urandom));
               end else begin
                  send_tick(16'($urandom), 16'($urandom));
               end
            end
         endcase
      end
      finish_burst();
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_TENSION;
      csr_wdata           <= '0;
      req_valid           <= 1'b0;
      req_type            <= 1'b0;
      req_tick_dt         <= '0;
      req_wave_gain       <= '0;
      req_splash_position <= '0;
      req_splash_speed    <= '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      quiet_cycles        = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings over the full 64 columns
      send_splash(10'd0, 32'sh7FFF_FFFF);
      send_splash(10'd945, 32'sh8000_0000);          // last column
      send_splash(10'd1023, 32'sh0001_0000);         // beyond the surface
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(16'd0, 16'd0);
      send_tick(16'h8000, 16'h4000);
      finish_burst();

      // stiff, heavily damped extremes on a short surface to drive saturation
      write_reg(CSR_TENSION, 16'hFFFF);
      write_reg(CSR_DAMPING, 16'hFFFF);
      write_reg(CSR_SPREAD, 16'hFFFF);
      write_reg(CSR_ACTIVE, 16'd0);                  // acts as two columns
      send_splash(10'd14, 32'sh8000_0000);
      send_splash(10'd30, 32'sh1234_5678);           // off a two-column surface
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(16'h0001, 16'hFFFF);
      finish_burst();

      write_reg(CSR_TENSION, 16'd0);
      write_reg(CSR_DAMPING, 16'd0);
      write_reg(CSR_SPREAD, 16'd0);
      write_reg(CSR_ACTIVE, 16'd127);                // clamps to full width
      send_splash(10'd480, 32'sh7FFF_FFFF);
      send_tick(16'hFFFF, 16'd1);
      finish_burst();
      write_reg(CSR_ACTIVE, 16'd1);                  // acts as two columns
      write_reg(CSR_ACTIVE, 16'd3);
      send_splash(10'd15, 32'sh4000_0000);           // middle column hits both neighbours
      send_splash(10'd44, -32'sd65536);
      send_tick(16'hFFFF, 16'h8000);
      send_tick(16'h1234, 16'hFFFF);
      finish_burst();

      // phase 1: no idling, reset-like coefficients, eight columns
      write_reg(CSR_TENSION, 16'd742);
      write_reg(CSR_DAMPING, 16'd590);
      write_reg(CSR_SPREAD, 16'd8960);
      write_reg(CSR_ACTIVE, 16'd8);
      random_items(45);

      // phase 2: sender mostly idle, random coefficients, small surface
      send_idle_pct = 81;
      write_reg(CSR_TENSION, 16'($urandom));
      write_reg(CSR_DAMPING, 16'($urandom));
      write_reg(CSR_SPREAD, 16'($urandom));
      write_reg(CSR_ACTIVE, 16'($urandom_range(6, 2)));
      random_items(45);

      // phase 3: receiver mostly stalled, heavy coupling
      send_idle_pct  = 0;
      recv_stall_pct = 81;
      write_reg(CSR_TENSION, 16'($urandom_range(2000)));
      write_reg(CSR_DAMPING, 16'($urandom));
      write_reg(CSR_SPREAD, 16'hFFFF);
      write_reg(CSR_ACTIVE, 16'($urandom_range(12, 4)));
      random_items(45);

      // phase 4: light idling on both sides, full width surface
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      write_reg(CSR_TENSION, 16'($urandom));
      write_reg(CSR_DAMPING, 16'($urandom));
      write_reg(CSR_SPREAD, 16'($urandom_range(12000)));
      write_reg(CSR_ACTIVE, 16'd64);
      random_items(40);

      repeat (50) @(posedge clock);
      if (fail_count == 0 && heights_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
